// File: sv/sbba_pkg.sv
// Shared types, constants and widths for the segregated bin block allocator.
`timescale 1ns / 1ps
package sbba_pkg;

    // Heap geometry
    localparam int HEAP_GRANULES = 4096;
    localparam int BIN_COUNT     = 128;
    localparam int GRAN_SHIFT    = 4;    // 16-byte granules
    localparam int GRAN_ROUND    = 15;   // rounds bytes up to a whole granule

    // Field widths fixed by the stream format
    localparam int ACT_W  = 1;
    localparam int REQ_W  = 16;
    localparam int ADDR_W = 12;
    localparam int ST_W   = 2;
    localparam int SW     = 13;          // stored block size in granules
    localparam int NW     = REQ_W - GRAN_SHIFT + 1; // granules needed, header included

    // Derived widths
    localparam int AW = $clog2(HEAP_GRANULES);
    localparam int BW = $clog2(BIN_COUNT);
    localparam int LW = $clog2(HEAP_GRANULES + 1);
    localparam int XW = ((AW > SW) ? AW : SW) + 2;  // compare width for sums

    // Stream widths
    localparam int S_TDATA_W = ((REQ_W + ADDR_W + 7) / 8) * 8;
    localparam int S_TUSER_W = ACT_W;
    localparam int M_TDATA_W = ((ADDR_W + 7) / 8) * 8;
    localparam int M_TUSER_W = ST_W + 1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_DONE        = 2'd0,
        ST_NULL        = 2'd1,
        ST_EXHAUSTED   = 2'd2,
        ST_DOUBLE_FREE = 2'd3
    } status_t;

    typedef struct packed {
        logic              action;
        logic [REQ_W-1:0]  bytes;
        logic [ADDR_W-1:0] addr;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] addr;
        logic              from_bin;
    } result_t;

    // Block table entry, one per header granule
    typedef struct packed {
        logic [SW-1:0] size;
        logic          piu;
        logic [AW-1:0] next;
    } blk_entry_t;

    // Bin table entry, one per bin
    typedef struct packed {
        logic [AW-1:0] first;
        logic [AW-1:0] last;
    } bin_entry_t;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        blk_entry_t    wdata;
    } blk_cmd_t;

    typedef struct packed {
        logic          we;
        logic [BW-1:0] addr;
        bin_entry_t    wdata;
    } bin_cmd_t;

endpackage

// File: sv/sbba_ram.sv
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module sbba_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: sv/sbba_ctrl.sv
// Request sequencer: read-modify-write of the block and bin tables.
`timescale 1ns / 1ps
module sbba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    output logic                req_ready,
    input  sbba_pkg::req_t      req,
    output logic                res_valid,
    input  logic                res_ready,
    output sbba_pkg::result_t   res,
    output sbba_pkg::blk_cmd_t  blk_cmd,
    input  sbba_pkg::blk_entry_t blk_rd,
    output sbba_pkg::bin_cmd_t  bin_cmd,
    input  sbba_pkg::bin_entry_t bin_rd
);
    import sbba_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_START    = 11'b00000000010,
        S_CARVE2   = 11'b00000000100,
        S_POP_BIN  = 11'b00000001000,
        S_POP_BLK  = 11'b00000010000,
        S_POP_MARK = 11'b00000100000,
        S_FREE_SZ  = 11'b00001000000,
        S_FREE_CHK = 11'b00010000000,
        S_LINK_RD  = 11'b00100000000,
        S_LINK_WR  = 11'b01000000000,
        S_FIN      = 11'b10000000000
    } state_t;

    state_t              state_reg, state_next;
    logic                act_reg, act_next;
    logic                zero_reg, zero_next;
    logic                hoob_reg, hoob_next;
    logic [NW-1:0]       need_reg, need_next;
    logic [BW-1:0]       b_reg, b_next;
    logic [AW-1:0]       h_reg, h_next;
    logic [AW-1:0]       n_reg, n_next;
    logic [AW-1:0]       last_reg, last_next;
    logic [AW-1:0]       top_reg, top_next;
    logic [LW-1:0]       left_reg, left_next;
    logic [BIN_COUNT-1:0] ne_reg, ne_next;
    result_t             res_reg, res_next;

    logic [REQ_W:0]      bytes_sum;
    logic [NW-1:0]       gran;
    logic [ADDR_W-1:0]   addr_m1;
    logic [XW-1:0]       n_full;
    logic [XW-1:0]       size_m1;
    logic [ADDR_W-1:0]   h_user;

    assign bytes_sum = {1'b0, req.bytes} + (REQ_W + 1)'(GRAN_ROUND);
    assign gran      = NW'(bytes_sum >> GRAN_SHIFT);
    assign addr_m1   = req.addr - ADDR_W'(1);
    assign n_full    = XW'(h_reg) + XW'(blk_rd.size);
    assign size_m1   = XW'(blk_rd.size) - XW'(1);
    assign h_user    = ADDR_W'(XW'(h_reg) + XW'(1));

    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        zero_next  = zero_reg;
        hoob_next  = hoob_reg;
        need_next  = need_reg;
        b_next     = b_reg;
        h_next     = h_reg;
        n_next     = n_reg;
        last_next  = last_reg;
        top_next   = top_reg;
        left_next  = left_reg;
        ne_next    = ne_reg;
        res_next   = res_reg;
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        blk_cmd    = '{we: 1'b0, addr: h_reg, wdata: '0};
        bin_cmd    = '{we: 1'b0, addr: b_reg, wdata: '0};

        case (state_reg)
            S_IDLE: begin
                req_ready = aresetn;
                if (req_valid && aresetn) begin
                    act_next  = req.action;
                    zero_next = (req.action == ACT_FREE) ? (req.addr == '0)
                                                         : (req.bytes == '0);
                    hoob_next = XW'(req.addr) > XW'(HEAP_GRANULES);
                    need_next = gran + NW'(1);
                    b_next    = (XW'(gran) < XW'(BIN_COUNT)) ? BW'(gran) : '0;
                    h_next    = AW'(addr_m1);
                    state_next = S_START;
                end
            end
            S_START: begin
                res_next = '{status: ST_DONE, addr: '0, from_bin: 1'b0};
                if (zero_reg) begin
                    res_next.status = ST_NULL;
                    state_next = S_FIN;
                end else if (act_reg == ACT_ALLOC) begin
                    if (b_reg != '0 && ne_reg[b_reg]) begin
                        state_next = S_POP_BIN;
                    end else if (XW'(need_reg) >= XW'(left_reg)) begin
                        res_next.status = ST_EXHAUSTED;
                        state_next = S_FIN;
                    end else begin
                        // carve the new block at the top
                        blk_cmd.we    = 1'b1;
                        blk_cmd.addr  = top_reg;
                        blk_cmd.wdata = '{size: SW'(need_reg), piu: 1'b1, next: '0};
                        h_next    = top_reg;
                        top_next  = top_reg + AW'(need_reg);
                        left_next = left_reg - LW'(need_reg);
                        state_next = S_CARVE2;
                    end
                end else if (hoob_reg) begin
                    res_next.status = ST_DOUBLE_FREE;
                    state_next = S_FIN;
                end else begin
                    state_next = S_FREE_SZ;
                end
            end
            S_CARVE2: begin
                // header of the remaining top block
                blk_cmd.we    = 1'b1;
                blk_cmd.addr  = top_reg;
                blk_cmd.wdata = '{size: SW'(left_reg), piu: 1'b1, next: '0};
                res_next.addr = h_user;
                state_next = S_FIN;
            end
            S_POP_BIN: begin
                h_next       = bin_rd.first;
                last_next    = bin_rd.last;
                blk_cmd.addr = bin_rd.first;
                state_next   = S_POP_BLK;
            end
            S_POP_BLK: begin
                if (h_reg == last_reg) begin
                    ne_next[b_reg] = 1'b0;
                end else begin
                    bin_cmd.we    = 1'b1;
                    bin_cmd.wdata = '{first: blk_rd.next, last: last_reg};
                end
                res_next.addr     = h_user;
                res_next.from_bin = 1'b1;
                if (n_full < XW'(HEAP_GRANULES)) begin
                    n_next       = AW'(n_full);
                    blk_cmd.addr = AW'(n_full);
                    state_next   = S_POP_MARK;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_POP_MARK: begin
                blk_cmd.we    = 1'b1;
                blk_cmd.addr  = n_reg;
                blk_cmd.wdata = '{size: blk_rd.size, piu: 1'b1, next: blk_rd.next};
                state_next = S_FIN;
            end
            S_FREE_SZ: begin
                if (n_full >= XW'(HEAP_GRANULES)) begin
                    res_next.status = ST_DOUBLE_FREE;
                    state_next = S_FIN;
                end else begin
                    n_next       = AW'(n_full);
                    blk_cmd.addr = AW'(n_full);
                    // zero sizes and sizes beyond the bin range fall into bin 0
                    if (blk_rd.size == '0 || size_m1 >= XW'(BIN_COUNT)) begin
                        b_next = '0;
                    end else begin
                        b_next = BW'(size_m1);
                    end
                    bin_cmd.addr = b_next;
                    state_next   = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                if (!blk_rd.piu) begin
                    res_next.status = ST_DOUBLE_FREE;
                    state_next = S_FIN;
                end else begin
                    blk_cmd.we    = 1'b1;
                    blk_cmd.addr  = n_reg;
                    blk_cmd.wdata = '{size: blk_rd.size, piu: 1'b0, next: blk_rd.next};
                    bin_cmd.we    = 1'b1;
                    bin_cmd.wdata = '{first: ne_reg[b_reg] ? bin_rd.first : h_reg,
                                      last: h_reg};
                    ne_next[b_reg] = 1'b1;
                    if (ne_reg[b_reg]) begin
                        last_next  = bin_rd.last;
                        state_next = S_LINK_RD;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_LINK_RD: begin
                blk_cmd.addr = last_reg;
                state_next   = S_LINK_WR;
            end
            S_LINK_WR: begin
                // chain the freed block behind the old tail
                blk_cmd.we    = 1'b1;
                blk_cmd.addr  = last_reg;
                blk_cmd.wdata = '{size: blk_rd.size, piu: blk_rd.piu, next: h_reg};
                state_next = S_FIN;
            end
            S_FIN: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            top_reg   <= '0;
            left_reg  <= LW'(HEAP_GRANULES);
            ne_reg    <= '0;
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
            left_reg  <= left_next;
            ne_reg    <= ne_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg  <= act_next;
        zero_reg <= zero_next;
        hoob_reg <= hoob_next;
        need_reg <= need_next;
        b_reg    <= b_next;
        h_reg    <= h_next;
        n_reg    <= n_next;
        last_reg <= last_next;
        res_reg  <= res_next;
    end

endmodule

// File: sv/segregated_bin_block_allocator.sv
// Top level of the segregated bin block allocator: stream ports, tables, result register.
`timescale 1ns / 1ps
// Heap allocator over 16-byte granules with 128 FIFO size bins.
// Input channel (s_): one request per handshake. s_tuser carries the action
// (allocate or free); s_tdata carries the byte count and the user granule
// address to free. Result channel (m_): one result per request, carrying
// the status and from-bin flag in m_tuser and the granted address in m_tdata.
// Each result waits on a chain of dependent accesses to the single-port
// block table, and the chain differs by request kind:
//   null request or exhausted heap  no table access
//   carve from the top              new block header, then top block header
//   allocation from a bin           bin head, block header, next block mark
//   free                            size, in-use check, tail link if bin is not empty
// One request is in work at a time; the next is taken in the cycle after the
// result moves to the output register. A stalled result blocks input only
// with a second one behind it.
// Reset (aresetn low, synchronous) holds s_tready low, empties every bin and
// returns the whole heap to the top block; table contents are left as they are.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits with its finished result until the register frees up.
module segregated_bin_block_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] request_bytes, [27:16] block_address, [31:28] zero
    input  logic [sbba_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] action
    input  logic [sbba_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [11:0] granted_address, [15:12] zero
    output logic [sbba_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status, [2] from_bin
    output logic [sbba_pkg::M_TUSER_W-1:0] m_tuser
);
    import sbba_pkg::*;

    req_t       req;
    result_t    res;
    logic       res_valid;
    logic       res_ready;
    blk_cmd_t   blk_cmd;
    blk_entry_t blk_rd;
    bin_cmd_t   bin_cmd;
    bin_entry_t bin_rd;

    logic       m_valid_reg;
    result_t    m_res_reg;

    // Unpack the request
    assign req.action = s_tuser[0];
    assign req.bytes  = s_tdata[REQ_W-1:0];
    assign req.addr   = s_tdata[REQ_W+ADDR_W-1:REQ_W];

    // Output register is free when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_tready;

    sbba_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .blk_cmd   (blk_cmd),
        .blk_rd    (blk_rd),
        .bin_cmd   (bin_cmd),
        .bin_rd    (bin_rd)
    );

    // Block table: size, previous-in-use mark and bin link per header granule
    sbba_ram #(
        .DATA_W ($bits(blk_entry_t)),
        .DEPTH  (HEAP_GRANULES)
    ) u_blk_ram (
        .aclk  (aclk),
        .we    (blk_cmd.we),
        .addr  (blk_cmd.addr),
        .wdata (blk_cmd.wdata),
        .rdata (blk_rd)
    );

    // Bin table: head and tail of each bin
    sbba_ram #(
        .DATA_W ($bits(bin_entry_t)),
        .DEPTH  (BIN_COUNT)
    ) u_bin_ram (
        .aclk  (aclk),
        .we    (bin_cmd.we),
        .addr  (bin_cmd.addr),
        .wdata (bin_cmd.wdata),
        .rdata (bin_rd)
    );

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_res_reg.addr);
    assign m_tuser  = {m_res_reg.from_bin, m_res_reg.status};

    // A granted address only comes with a completed request
    a_addr_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[ADDR_W-1:0] != '0) |-> (m_tuser[ST_W-1:0] == ST_DONE))
        else $error("granted address with a failed status");

    // A bin hit is always a completed request
    a_bin_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[ST_W]) |-> (m_tuser[ST_W-1:0] == ST_DONE))
        else $error("bin hit flagged on a failed request");

    // One request in work at a time: no input taken right after one is accepted
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in work");

endmodule
